[hw/rtl/i2cm_pkg.sv]
// shared types, codes and constants of the i2c register access master
package i2cm_pkg;

  localparam int TX_DEPTH_DEFAULT = 16;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
  localparam logic [1:0]  ADDR_BYTES_RESET  = 2'd1;

  localparam logic [1:0] OPC_TICK  = 2'd0;
  localparam logic [1:0] OPC_PUSH  = 2'd1;
  localparam logic [1:0] OPC_BEGIN = 2'd2;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_ADDR_BYTES  = 2'd1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_PUSH  = 2'd2,
    KIND_BEGIN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NACK   = 2'd1,
    STATUS_QEMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    UNIT_DEVW = 3'd0,
    UNIT_REGH = 3'd1,
    UNIT_REGL = 3'd2,
    UNIT_DATA = 3'd3,
    UNIT_DEVR = 3'd4
  } unit_t;

  typedef enum logic [16:0] {
    PH_IDLE = 17'b00000000000000001,
    PH_ST1  = 17'b00000000000000010,
    PH_ST2  = 17'b00000000000000100,
    PH_TXL  = 17'b00000000000001000,
    PH_TXH  = 17'b00000000000010000,
    PH_AKL  = 17'b00000000000100000,
    PH_AKH  = 17'b00000000001000000,
    PH_RS1  = 17'b00000000010000000,
    PH_RS2  = 17'b00000000100000000,
    PH_RS3  = 17'b00000001000000000,
    PH_RXL  = 17'b00000010000000000,
    PH_RXH  = 17'b00000100000000000,
    PH_MAL  = 17'b00001000000000000,
    PH_MAH  = 17'b00010000000000000,
    PH_SP1  = 17'b00100000000000000,
    PH_SP2  = 17'b01000000000000000,
    PH_SP3  = 17'b10000000000000000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic        sda_sample;
    logic [7:0]  data_byte;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic        is_read;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       done_res;
    status_t    status;
    logic       busy_res;
  } result_t;

endpackage

[hw/rtl/i2cm_ram.sv]
// generic single write port ram with registered read
module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/i2cm_front.sv]
// input side: takes items, classifies the opcode and holds them for the engine
module i2cm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          opcode,
  input  logic                sda_sample,
  input  logic [7:0]          data_byte,
  input  logic [6:0]          device_address,
  input  logic [15:0]         register_address,
  input  logic [7:0]          byte_count,
  input  logic                is_read,
  output logic                item_valid,
  output i2cm_pkg::item_t     item,
  input  logic                item_pop
);

  i2cm_pkg::item_t slot [2];
  i2cm_pkg::item_t incoming;
  i2cm_pkg::kind_t kind;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            accept;

  always_comb begin
    case (opcode)
      i2cm_pkg::OPC_TICK:  kind = i2cm_pkg::KIND_TICK;
      i2cm_pkg::OPC_PUSH:  kind = i2cm_pkg::KIND_PUSH;
      i2cm_pkg::OPC_BEGIN: kind = i2cm_pkg::KIND_BEGIN;
      default:             kind = i2cm_pkg::KIND_NONE;
    endcase
  end

  assign incoming = '{kind: kind, sda_sample: sda_sample, data_byte: data_byte,
                      device_address: device_address,
                      register_address: register_address,
                      byte_count: byte_count, is_read: is_read};

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, item_pop};
    end
  end

endmodule

[hw/rtl/i2cm_engine.sv]
// bus engine: phase machine, bit timing, transmit queue and configuration registers
module i2cm_engine #(
  parameter int TX_DEPTH = i2cm_pkg::TX_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  input  i2cm_pkg::item_t   item,
  output logic              item_pop,
  input  logic              res_full,
  output logic              res_push,
  output i2cm_pkg::result_t res
);

  localparam int PTR_W  = $clog2(TX_DEPTH);
  localparam int FILL_W = $clog2(TX_DEPTH + 1);

  logic [15:0]       half_period;
  logic [1:0]        addr_bytes;

  i2cm_pkg::phase_t  phase, phase_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [6:0]        target_addr, target_addr_next;
  logic [15:0]       word_addr, word_addr_next;
  logic              read_mode, read_mode_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [FILL_W-1:0] queue_fill, queue_fill_next;
  logic              scl_reg, scl_reg_next;
  logic              sda_reg, sda_reg_next;
  i2cm_pkg::unit_t   cur_unit, cur_unit_next;
  i2cm_pkg::status_t fail_code, fail_code_next;
  logic              byp_valid;
  logic [7:0]        byp_data;

  logic              fire;
  logic              entered;
  logic              do_send;
  logic [7:0]        send_val;
  i2cm_pkg::unit_t   send_unit;
  logic              do_data;
  logic [15:0]       half_eff;
  logic [15:0]       tick_inc;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_inc;
  logic [7:0]        head_byte;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic              rx_valid;
  logic [7:0]        rx_byte;
  logic              rx_last;
  logic              done;
  i2cm_pkg::status_t status;

  i2cm_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_txq (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (item.data_byte),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  assign fire      = item_valid && !res_full;
  assign item_pop  = fire;
  assign res_push  = fire;
  assign half_eff  = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_inc  = tick_count + 16'd1;
  assign tail_sum  = {1'b0, head} + (PTR_W+1)'(queue_fill);
  assign tail      = (tail_sum >= (PTR_W+1)'(TX_DEPTH)) ?
                     PTR_W'(tail_sum - (PTR_W+1)'(TX_DEPTH)) : tail_sum[PTR_W-1:0];
  assign head_inc  = (head == PTR_W'(TX_DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_byte = byp_valid ? byp_data : rd_data;

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    bytes_left_next  = bytes_left;
    target_addr_next = target_addr;
    word_addr_next   = word_addr;
    read_mode_next   = read_mode;
    head_next        = head;
    queue_fill_next  = queue_fill;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    cur_unit_next    = cur_unit;
    fail_code_next   = fail_code;
    entered          = 1'b0;
    do_send          = 1'b0;
    send_val         = 8'd0;
    send_unit        = cur_unit;
    do_data          = 1'b0;
    wr_en            = 1'b0;
    rx_valid         = 1'b0;
    rx_byte          = 8'd0;
    rx_last          = 1'b0;
    done             = 1'b0;
    status           = i2cm_pkg::STATUS_OK;

    if (fire) begin
      case (item.kind)
        i2cm_pkg::KIND_PUSH: begin
          if (queue_fill < FILL_W'(TX_DEPTH)) begin
            wr_en           = 1'b1;
            queue_fill_next = queue_fill + 1'b1;
          end
        end
        i2cm_pkg::KIND_BEGIN: begin
          if (phase == i2cm_pkg::PH_IDLE) begin
            target_addr_next = item.device_address;
            word_addr_next   = item.register_address;
            bytes_left_next  = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
            read_mode_next   = item.is_read;
            fail_code_next   = i2cm_pkg::STATUS_OK;
            phase_next       = i2cm_pkg::PH_ST1;
            entered          = 1'b1;
          end
        end
        i2cm_pkg::KIND_TICK: begin
          if (phase != i2cm_pkg::PH_IDLE) begin
            tick_count_next = tick_inc;
            if (tick_inc >= half_eff) begin
              case (phase)
                i2cm_pkg::PH_ST1: begin
                  phase_next = i2cm_pkg::PH_ST2;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_ST2: begin
                  do_send   = 1'b1;
                  send_val  = {target_addr, 1'b0};
                  send_unit = i2cm_pkg::UNIT_DEVW;
                end
                i2cm_pkg::PH_TXL: begin
                  phase_next = i2cm_pkg::PH_TXH;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_TXH: begin
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  bit_index_next = bit_index + 4'd1;
                  phase_next     = (bit_index_next >= 4'd8) ? i2cm_pkg::PH_AKL
                                                             : i2cm_pkg::PH_TXL;
                  entered        = 1'b1;
                end
                i2cm_pkg::PH_AKL: begin
                  phase_next = i2cm_pkg::PH_AKH;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_AKH: begin
                  if (item.sda_sample) begin
                    fail_code_next = i2cm_pkg::STATUS_NACK;
                    phase_next     = i2cm_pkg::PH_SP1;
                    entered        = 1'b1;
                  end else begin
                    case (cur_unit)
                      i2cm_pkg::UNIT_DEVW: begin
                        do_send = 1'b1;
                        if (addr_bytes >= 2'd2) begin
                          send_val  = word_addr[15:8];
                          send_unit = i2cm_pkg::UNIT_REGH;
                        end else begin
                          send_val  = word_addr[7:0];
                          send_unit = i2cm_pkg::UNIT_REGL;
                        end
                      end
                      i2cm_pkg::UNIT_REGH: begin
                        do_send   = 1'b1;
                        send_val  = word_addr[7:0];
                        send_unit = i2cm_pkg::UNIT_REGL;
                      end
                      i2cm_pkg::UNIT_REGL: begin
                        if (read_mode) begin
                          phase_next = i2cm_pkg::PH_RS1;
                          entered    = 1'b1;
                        end else begin
                          do_data = 1'b1;
                        end
                      end
                      i2cm_pkg::UNIT_DATA: begin
                        bytes_left_next = bytes_left - 8'd1;
                        if (bytes_left_next == 8'd0) begin
                          phase_next = i2cm_pkg::PH_SP1;
                          entered    = 1'b1;
                        end else begin
                          do_data = 1'b1;
                        end
                      end
                      default: begin
                        bit_index_next = 4'd0;
                        shift_reg_next = 8'd0;
                        phase_next     = i2cm_pkg::PH_RXL;
                        entered        = 1'b1;
                      end
                    endcase
                  end
                end
                i2cm_pkg::PH_RS1: begin
                  phase_next = i2cm_pkg::PH_RS2;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_RS2: begin
                  phase_next = i2cm_pkg::PH_RS3;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_RS3: begin
                  do_send   = 1'b1;
                  send_val  = {target_addr, 1'b1};
                  send_unit = i2cm_pkg::UNIT_DEVR;
                end
                i2cm_pkg::PH_RXL: begin
                  phase_next = i2cm_pkg::PH_RXH;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_RXH: begin
                  shift_reg_next = {shift_reg[6:0], item.sda_sample};
                  bit_index_next = bit_index + 4'd1;
                  entered        = 1'b1;
                  if (bit_index_next >= 4'd8) begin
                    rx_valid   = 1'b1;
                    rx_byte    = shift_reg_next;
                    rx_last    = (bytes_left <= 8'd1);
                    phase_next = i2cm_pkg::PH_MAL;
                  end else begin
                    phase_next = i2cm_pkg::PH_RXL;
                  end
                end
                i2cm_pkg::PH_MAL: begin
                  phase_next = i2cm_pkg::PH_MAH;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_MAH: begin
                  bytes_left_next = bytes_left - 8'd1;
                  entered         = 1'b1;
                  if (bytes_left_next == 8'd0) begin
                    phase_next = i2cm_pkg::PH_SP1;
                  end else begin
                    bit_index_next = 4'd0;
                    shift_reg_next = 8'd0;
                    phase_next     = i2cm_pkg::PH_RXL;
                  end
                end
                i2cm_pkg::PH_SP1: begin
                  phase_next = i2cm_pkg::PH_SP2;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_SP2: begin
                  phase_next = i2cm_pkg::PH_SP3;
                  entered    = 1'b1;
                end
                i2cm_pkg::PH_SP3: begin
                  done       = 1'b1;
                  status     = fail_code;
                  if (!read_mode) begin
                    queue_fill_next = '0;
                  end
                  phase_next = i2cm_pkg::PH_IDLE;
                  entered    = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    if (do_send) begin
      cur_unit_next  = send_unit;
      shift_reg_next = send_val;
      bit_index_next = 4'd0;
      phase_next     = i2cm_pkg::PH_TXL;
      entered        = 1'b1;
    end

    // next write byte from the queue, or abort on an empty queue
    if (do_data) begin
      entered = 1'b1;
      if (queue_fill == '0) begin
        fail_code_next = i2cm_pkg::STATUS_QEMPTY;
        phase_next     = i2cm_pkg::PH_SP1;
      end else begin
        shift_reg_next  = head_byte;
        head_next       = head_inc;
        queue_fill_next = queue_fill - 1'b1;
        cur_unit_next   = i2cm_pkg::UNIT_DATA;
        bit_index_next  = 4'd0;
        phase_next      = i2cm_pkg::PH_TXL;
      end
    end

    // line levels of the phase just entered
    if (entered) begin
      tick_count_next = 16'd0;
      case (phase_next)
        i2cm_pkg::PH_ST2, i2cm_pkg::PH_RS3, i2cm_pkg::PH_SP2: begin
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b0;
        end
        i2cm_pkg::PH_TXL: begin
          scl_reg_next = 1'b0;
          sda_reg_next = shift_reg_next[7];
        end
        i2cm_pkg::PH_TXH: begin
          scl_reg_next = 1'b1;
          sda_reg_next = shift_reg_next[7];
        end
        i2cm_pkg::PH_AKL, i2cm_pkg::PH_RXL, i2cm_pkg::PH_RS1: begin
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b1;
        end
        i2cm_pkg::PH_MAL: begin
          scl_reg_next = 1'b0;
          sda_reg_next = (bytes_left_next <= 8'd1);
        end
        i2cm_pkg::PH_MAH: begin
          scl_reg_next = 1'b1;
          sda_reg_next = (bytes_left_next <= 8'd1);
        end
        i2cm_pkg::PH_SP1: begin
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b0;
        end
        default: begin
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
        end
      endcase
    end
  end

  assign res = '{scl_level: scl_reg_next, sda_release: sda_reg_next,
                 rx_valid: rx_valid, rx_byte: rx_byte, rx_last: rx_last,
                 done_res: done, status: status,
                 busy_res: (phase_next != i2cm_pkg::PH_IDLE)};

  always_ff @(posedge clk) begin
    byp_data <= item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
      addr_bytes  <= i2cm_pkg::ADDR_BYTES_RESET;
      phase       <= i2cm_pkg::PH_IDLE;
      tick_count  <= 16'd0;
      bit_index   <= 4'd0;
      shift_reg   <= 8'd0;
      bytes_left  <= 8'd0;
      target_addr <= 7'd0;
      word_addr   <= 16'd0;
      read_mode   <= 1'b0;
      head        <= '0;
      queue_fill  <= '0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      cur_unit    <= i2cm_pkg::UNIT_DEVW;
      fail_code   <= i2cm_pkg::STATUS_OK;
      byp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2cm_pkg::CFG_HALF_PERIOD: half_period <= cfg_data;
          i2cm_pkg::CFG_ADDR_BYTES:  addr_bytes  <= cfg_data[1:0];
          default: ;
        endcase
      end
      // the registered ram read misses a write to the address read in the same cycle, so that byte is bypassed
      byp_valid <= wr_en && (tail == head_next);
      if (fire) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        bit_index   <= bit_index_next;
        shift_reg   <= shift_reg_next;
        bytes_left  <= bytes_left_next;
        target_addr <= target_addr_next;
        word_addr   <= word_addr_next;
        read_mode   <= read_mode_next;
        head        <= head_next;
        queue_fill  <= queue_fill_next;
        scl_reg     <= scl_reg_next;
        sda_reg     <= sda_reg_next;
        cur_unit    <= cur_unit_next;
        fail_code   <= fail_code_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    queue_fill <= FILL_W'(TX_DEPTH))
    else $error("transmit queue fill beyond depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.done_res) |-> !res.busy_res)
    else $error("done reported while still busy");

  a_rx_read: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.rx_valid) |-> read_mode)
    else $error("received byte outside a read");

  a_begin_start: assert property (@(posedge clk) disable iff (rst)
    (fire && item.kind == i2cm_pkg::KIND_BEGIN && phase == i2cm_pkg::PH_IDLE)
    |=> (phase == i2cm_pkg::PH_ST1 && tick_count == 16'd0))
    else $error("begin did not start a transaction");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res.done_res) |-> (res.status == i2cm_pkg::STATUS_OK))
    else $error("status set without done");
`endif

endmodule

[hw/rtl/i2cm_result_q.sv]
// output side: two entry result queue toward the consumer
module i2cm_result_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  i2cm_pkg::result_t res,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output i2cm_pkg::result_t head_res
);

  i2cm_pkg::result_t slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              take;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign take     = pop && !empty;
  assign head_res = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, take};
    end
  end

endmodule

[hw/rtl/i2c_master_register_access.sv]
// top level of the i2c master for register reads and writes
// Takes one item (tick, queue write byte or begin) per clock and gives one result per
// item, while the result queue has room. The bus engine handles each item as it is
// taken; items wait in a two entry input queue and results in a two entry result queue.
// SCL and SDA move only on tick items, one line phase per half_period_ticks ticks (a
// value of zero acts as one). Write data waits in a TX_DEPTH entry ram, read ahead of
// its use through the registered read port; it needs no clearing after reset.
// Configuration writes take effect at the next clock.
module i2c_master_register_access #(
  parameter int TX_DEPTH = i2cm_pkg::TX_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic        sda_sample,
  input  logic [7:0]  data_byte,
  input  logic [6:0]  device_address,
  input  logic [15:0] register_address,
  input  logic [7:0]  byte_count,
  input  logic        is_read,
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_release,
  output logic        rx_valid,
  output logic [7:0]  rx_byte,
  output logic        rx_last,
  output logic        done_res,
  output logic [1:0]  status,
  output logic        busy_res
);

  i2cm_pkg::item_t   item;
  logic              item_valid;
  logic              item_pop;
  i2cm_pkg::result_t res;
  logic              res_push;
  logic              res_full;
  i2cm_pkg::result_t head_res;

  i2cm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .opcode           (opcode),
    .sda_sample       (sda_sample),
    .data_byte        (data_byte),
    .device_address   (device_address),
    .register_address (register_address),
    .byte_count       (byte_count),
    .is_read          (is_read),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  i2cm_engine #(.TX_DEPTH(TX_DEPTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  i2cm_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head_res (head_res)
  );

  assign scl_level   = head_res.scl_level;
  assign sda_release = head_res.sda_release;
  assign rx_valid    = head_res.rx_valid;
  assign rx_byte     = head_res.rx_byte;
  assign rx_last     = head_res.rx_last;
  assign done_res    = head_res.done_res;
  assign status      = head_res.status;
  assign busy_res    = head_res.busy_res;

endmodule

[tb/tb_i2c_master_register_access.sv]
// self-checking testbench of the i2c register access master, with a bus-level predictor
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
  import i2cm_pkg::*;

  localparam int          TXQ_DEPTH    = TX_DEPTH_DEFAULT;
  localparam logic [1:0]  OPC_SPARE    = 2'd3;
  localparam logic [1:0]  CFG_SPARE2   = 2'd2;
  localparam logic [1:0]  CFG_SPARE3   = 2'd3;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        sda_sample;
    logic [7:0]  data_byte;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic        is_read;
  } bus_item_t;

  logic        clk;
  logic        rst              = 1'b1;
  logic        cfg_we           = 1'b0;
  logic [1:0]  cfg_index        = '0;
  logic [15:0] cfg_data         = '0;
  logic        push             = 1'b0;
  logic        full;
  logic [1:0]  opcode           = '0;
  logic        sda_sample       = 1'b0;
  logic [7:0]  data_byte        = '0;
  logic [6:0]  device_address   = '0;
  logic [15:0] register_address = '0;
  logic [7:0]  byte_count       = '0;
  logic        is_read          = 1'b0;
  logic        empty;
  logic        pop              = 1'b0;
  logic        scl_level;
  logic        sda_release;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        rx_last;
  logic        done_res;
  logic [1:0]  status;
  logic        busy_res;

  i2c_master_register_access u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .opcode           (opcode),
    .sda_sample       (sda_sample),
    .data_byte        (data_byte),
    .device_address   (device_address),
    .register_address (register_address),
    .byte_count       (byte_count),
    .is_read          (is_read),
    .empty            (empty),
    .pop              (pop),
    .scl_level        (scl_level),
    .sda_release      (sda_release),
    .rx_valid         (rx_valid),
    .rx_byte          (rx_byte),
    .rx_last          (rx_last),
    .done_res         (done_res),
    .status           (status),
    .busy_res         (busy_res)
  );

  // predictor state
  logic [15:0] cfg_half       = HALF_PERIOD_RESET;
  logic [1:0]  cfg_abytes     = ADDR_BYTES_RESET;
  phase_t      bus_phase      = PH_IDLE;
  int unsigned tick_cnt       = 0;
  int unsigned bit_cnt        = 0;
  logic [7:0]  shifter        = '0;
  logic [7:0]  bytes_to_go    = '0;
  logic [6:0]  dev_addr       = '0;
  logic [15:0] reg_addr       = '0;
  logic        read_xfer      = 1'b0;
  logic [7:0]  wr_fifo[$];
  logic        scl_drv        = 1'b1;
  logic        sda_drv        = 1'b1;
  unit_t       byte_kind      = UNIT_DEVW;
  status_t     pending_status = STATUS_OK;

  result_t     expected_results[$];

  bit          steady        = 1'b0;
  int          nack_pct      = 0;
  int          noise_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned full_stalls   = 0;
  int unsigned items_sent    = 0;
  int unsigned noise_sent    = 0;
  int unsigned transfers     = 0;
  int unsigned done_ok       = 0;
  int unsigned done_nack     = 0;
  int unsigned done_qempty   = 0;
  int unsigned bytes_read    = 0;
  int unsigned errors        = 0;

  function automatic void set_phase(input phase_t p);
    bus_phase = p;
    tick_cnt  = 0;
    case (p)
      PH_ST2, PH_RS3, PH_SP2: begin
        scl_drv = 1'b1;
        sda_drv = 1'b0;
      end
      PH_TXL: begin
        scl_drv = 1'b0;
        sda_drv = shifter[7];
      end
      PH_TXH: begin
        scl_drv = 1'b1;
        sda_drv = shifter[7];
      end
      PH_AKL, PH_RXL, PH_RS1: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
      end
      PH_MAL: begin
        scl_drv = 1'b0;
        sda_drv = (bytes_to_go <= 8'd1);
      end
      PH_MAH: begin
        scl_drv = 1'b1;
        sda_drv = (bytes_to_go <= 8'd1);
      end
      PH_SP1: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
      end
      default: begin
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
    endcase
  endfunction

  function automatic void start_byte(input logic [7:0] value, input unit_t kind);
    byte_kind = kind;
    shifter   = value;
    bit_cnt   = 0;
    set_phase(PH_TXL);
  endfunction

  function automatic void stop_with(input status_t code);
    pending_status = code;
    set_phase(PH_SP1);
  endfunction

  function automatic void take_write_byte();
    if (wr_fifo.size() == 0) stop_with(STATUS_QEMPTY);
    else start_byte(wr_fifo.pop_front(), UNIT_DATA);
  endfunction

  function automatic void on_ack();
    case (byte_kind)
      UNIT_DEVW: begin
        if (cfg_abytes >= 2'd2) start_byte(reg_addr[15:8], UNIT_REGH);
        else start_byte(reg_addr[7:0], UNIT_REGL);
      end
      UNIT_REGH: start_byte(reg_addr[7:0], UNIT_REGL);
      UNIT_REGL: begin
        if (read_xfer) set_phase(PH_RS1);
        else take_write_byte();
      end
      UNIT_DATA: begin
        bytes_to_go--;
        if (bytes_to_go == 8'd0) set_phase(PH_SP1);
        else take_write_byte();
      end
      default: begin
        bit_cnt = 0;
        shifter = '0;
        set_phase(PH_RXL);
      end
    endcase
  endfunction

  function automatic result_t bus_step(input bus_item_t it);
    result_t     r;
    int unsigned span;
    r    = '0;
    span = (cfg_half == 16'd0) ? 1 : cfg_half;
    case (it.opcode)
      OPC_PUSH: begin
        if (wr_fifo.size() < TXQ_DEPTH) wr_fifo.push_back(it.data_byte);
      end
      OPC_BEGIN: begin
        if (bus_phase == PH_IDLE) begin
          dev_addr       = it.device_address;
          reg_addr       = it.register_address;
          bytes_to_go    = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
          read_xfer      = it.is_read;
          pending_status = STATUS_OK;
          set_phase(PH_ST1);
        end
      end
      OPC_TICK: begin
        if (bus_phase != PH_IDLE) begin
          tick_cnt++;
          if (tick_cnt >= span) begin
            case (bus_phase)
              PH_ST1: set_phase(PH_ST2);
              PH_ST2: start_byte({dev_addr, 1'b0}, UNIT_DEVW);
              PH_TXL: set_phase(PH_TXH);
              PH_TXH: begin
                shifter = shifter << 1;
                bit_cnt++;
                if (bit_cnt >= 8) set_phase(PH_AKL);
                else set_phase(PH_TXL);
              end
              PH_AKL: set_phase(PH_AKH);
              PH_AKH: begin
                if (it.sda_sample) stop_with(STATUS_NACK);
                else on_ack();
              end
              PH_RS1: set_phase(PH_RS2);
              PH_RS2: set_phase(PH_RS3);
              PH_RS3: start_byte({dev_addr, 1'b1}, UNIT_DEVR);
              PH_RXL: set_phase(PH_RXH);
              PH_RXH: begin
                shifter = {shifter[6:0], it.sda_sample};
                bit_cnt++;
                if (bit_cnt >= 8) begin
                  r.rx_valid = 1'b1;
                  r.rx_byte  = shifter;
                  r.rx_last  = (bytes_to_go <= 8'd1);
                  set_phase(PH_MAL);
                end else begin
                  set_phase(PH_RXL);
                end
              end
              PH_MAL: set_phase(PH_MAH);
              PH_MAH: begin
                bytes_to_go--;
                if (bytes_to_go == 8'd0) begin
                  set_phase(PH_SP1);
                end else begin
                  bit_cnt = 0;
                  shifter = '0;
                  set_phase(PH_RXL);
                end
              end
              PH_SP1: set_phase(PH_SP2);
              PH_SP2: set_phase(PH_SP3);
              default: begin
                r.done_res = 1'b1;
                r.status   = pending_status;
                // a write always leaves the data queue empty
                if (!read_xfer) wr_fifo.delete();
                set_phase(PH_IDLE);
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    r.scl_level   = scl_drv;
    r.sda_release = sda_drv;
    r.busy_res    = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void set_register(input logic [1:0] idx, input logic [15:0] value);
    case (idx)
      CFG_HALF_PERIOD: cfg_half = value;
      CFG_ADDR_BYTES:  cfg_abytes = value[1:0];
      default: ;
    endcase
  endfunction

  function automatic bus_item_t rand_item();
    bus_item_t it;
    it.opcode           = $urandom_range(0, 3);
    it.sda_sample       = $urandom_range(0, 1);
    it.data_byte        = $urandom_range(0, 255);
    it.device_address   = $urandom_range(0, 127);
    it.register_address = $urandom_range(0, 65535);
    it.byte_count       = $urandom_range(0, 255);
    it.is_read          = $urandom_range(0, 1);
    return it;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (push && full) full_stalls++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check each transfer, then decide pop for the next edge
  always @(posedge clk) begin : result_side
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          $error("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("scl_level", want.scl_level, scl_level);
          check_field("sda_release", want.sda_release, sda_release);
          check_field("rx_valid", want.rx_valid, rx_valid);
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_field("rx_last", want.rx_last, rx_last);
          check_field("done_res", want.done_res, done_res);
          check_field("status", want.status, status);
          check_field("busy_res", want.busy_res, busy_res);
          transfers++;
          if (want.rx_valid) bytes_read++;
          if (want.done_res) begin
            case (want.status)
              STATUS_NACK:   done_nack++;
              STATUS_QEMPTY: done_qempty++;
              default:       done_ok++;
            endcase
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_started != hold_requests) begin
        holds_started++;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic send_item(input bus_item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push             <= 1'b1;
    opcode           <= it.opcode;
    sda_sample       <= it.sda_sample;
    data_byte        <= it.data_byte;
    device_address   <= it.device_address;
    register_address <= it.register_address;
    byte_count       <= it.byte_count;
    is_read          <= it.is_read;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(bus_step(it));
    items_sent++;
  endtask

  task automatic send_tick();
    bus_item_t it;
    it        = rand_item();
    it.opcode = OPC_TICK;
    if (bus_phase == PH_AKH) it.sda_sample = ($urandom_range(0, 99) < nack_pct);
    send_item(it);
  endtask

  task automatic send_spare();
    bus_item_t it;
    it        = rand_item();
    it.opcode = OPC_SPARE;
    send_item(it);
  endtask

  task automatic push_byte(input logic [7:0] value);
    bus_item_t it;
    it           = rand_item();
    it.opcode    = OPC_PUSH;
    it.data_byte = value;
    send_item(it);
  endtask

  task automatic begin_xfer(input logic [6:0] dev, input logic [15:0] word,
                            input logic [7:0] count, input logic rd);
    bus_item_t it;
    it                  = rand_item();
    it.opcode           = OPC_BEGIN;
    it.device_address   = dev;
    it.register_address = word;
    it.byte_count       = count;
    it.is_read          = rd;
    send_item(it);
  endtask

  task automatic run_to_idle();
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        noise_sent++;
        send_item(rand_item());
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_register(idx, value);
  endtask

  task automatic test_reset_defaults();
    send_spare();
    send_tick();
    send_spare();
    write_cfg(CFG_SPARE2, 16'hFFFF);
    write_cfg(CFG_SPARE3, 16'h0000);
    push_byte(8'hFF);
    begin_xfer(7'h7F, 16'hFFFF, 8'd1, 1'b0);
    run_to_idle();
  endtask

  task automatic test_zero_fields();
    write_cfg(CFG_HALF_PERIOD, 16'd1);
    write_cfg(CFG_ADDR_BYTES, 16'd2);
    push_byte(8'h00);
    begin_xfer(7'h00, 16'h0000, 8'd0, 1'b0);
    run_to_idle();
    begin_xfer(7'h2A, 16'hA55A, 8'd3, 1'b1);
    run_to_idle();
  endtask

  task automatic test_nack();
    push_byte(8'h11);
    push_byte(8'h22);
    nack_pct = 100;
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd2, 1'b0);
    run_to_idle();
    nack_pct = 0;
    // queue was flushed by the failed write
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd1, 1'b0);
    run_to_idle();
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd2, 1'b1);
    while (byte_kind != UNIT_DEVR || bus_phase != PH_AKH) send_tick();
    nack_pct = 100;
    run_to_idle();
    nack_pct = 0;
  endtask

  task automatic test_full_queue();
    bus_item_t it;
    for (int i = 0; i <= TXQ_DEPTH; i++) push_byte($urandom_range(0, 255));
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd255, 1'b0);
    repeat (40) send_tick();
    it        = rand_item();
    it.opcode = OPC_BEGIN;
    send_item(it);
    send_spare();
    run_to_idle();
  endtask

  task automatic test_read_keeps_queue();
    write_cfg(CFG_HALF_PERIOD, 16'd0);
    write_cfg(CFG_ADDR_BYTES, 16'd3);
    push_byte(8'h5A);
    push_byte(8'hA5);
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd1, 1'b1);
    run_to_idle();
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd2, 1'b0);
    run_to_idle();
    write_cfg(CFG_ADDR_BYTES, 16'd0);
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd2, 1'b1);
    run_to_idle();
  endtask

  task automatic test_long_read();
    write_cfg(CFG_HALF_PERIOD, 16'd1);
    write_cfg(CFG_ADDR_BYTES, 16'd1);
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd255, 1'b1);
    run_to_idle();
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_HALF_PERIOD, 16'd2);
    steady = 1'b1;
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), 8'd4, 1'b1);
    hold_requests++;
    run_to_idle();
    steady = 1'b0;
  endtask

  task automatic test_random();
    int unsigned base;
    int unsigned done_items;
    int unsigned count;
    int unsigned fill;
    logic        rd;
    base      = items_sent - noise_sent;
    nack_pct  = 6;
    noise_pct = 3;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      steady = (done_items >= 400 && done_items < 700);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 3) == 0) write_cfg(CFG_HALF_PERIOD, $urandom_range(2, 3));
        else write_cfg(CFG_HALF_PERIOD, $urandom_range(0, 1));
        write_cfg(CFG_ADDR_BYTES, $urandom_range(0, 65535));
      end
      rd    = $urandom_range(0, 1);
      count = $urandom_range(0, 3);
      fill  = (count == 0) ? 1 : count;
      // now and then short the write data to hit the empty queue case
      if ($urandom_range(0, 9) == 0) fill = $urandom_range(0, fill - 1);
      if (!rd || $urandom_range(0, 3) == 0) repeat (fill) push_byte($urandom_range(0, 255));
      begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535), count, rd);
      run_to_idle();
      done_items = items_sent - noise_sent - base;
    end
    steady    = 1'b0;
    nack_pct  = 0;
    noise_pct = 0;
  endtask

  task automatic test_max_half_period();
    write_cfg(CFG_HALF_PERIOD, 16'hFFFF);
    write_cfg(CFG_ADDR_BYTES, 16'd1);
    steady = 1'b1;
    begin_xfer($urandom_range(0, 127), $urandom_range(0, 65535),
               $urandom_range(1, 255), $urandom_range(0, 1));
    // one start phase needs the full tick count before it moves on
    repeat (65540) send_tick();
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_fields();
    test_nack();
    test_full_queue();
    test_read_keeps_queue();
    test_long_read();
    test_backpressure();
    test_random();
    test_max_half_period();
    drain();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $error("%0d results never arrived", expected_results.size());
    end
    $display("%0d transfers checked; bus transactions: %0d ok, %0d no ack, %0d queue empty",
             transfers, done_ok, done_nack, done_qempty);
    $display("%0d bytes read, %0d noise items, input held off by full for %0d cycles",
             bytes_read, noise_sent, full_stalls);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
